### design/aofc_pkg.sv
// Shared types and constants for the box overlap and nearest-face classifier.
// No dependencies; used by every module of the block.
package aofc_pkg;

  // Field widths of one transaction
  localparam int CoordWidth = 24;
  localparam int SizeWidth  = 20;
  localparam int NumGaps    = 6;

  // Extents are formed at doubled scale; this width holds any extent and any gap
  localparam int ExtWidth = ((CoordWidth > SizeWidth) ? CoordWidth : SizeWidth) + 2;

  // Face codes reported on side
  localparam logic [2:0] SideLeft   = 3'd0;
  localparam logic [2:0] SideRight  = 3'd1;
  localparam logic [2:0] SideTop    = 3'd2;
  localparam logic [2:0] SideBottom = 3'd3;
  localparam logic [2:0] SideFront  = 3'd4;
  localparam logic [2:0] SideBehind = 3'd5;

  typedef struct packed {
    logic signed [CoordWidth-1:0] a_center_x;
    logic signed [CoordWidth-1:0] a_center_y;
    logic signed [CoordWidth-1:0] a_center_z;
    logic signed [CoordWidth-1:0] b_center_x;
    logic signed [CoordWidth-1:0] b_center_y;
    logic signed [CoordWidth-1:0] b_center_z;
    logic [SizeWidth-1:0]         a_size_x;
    logic [SizeWidth-1:0]         a_size_y;
    logic [SizeWidth-1:0]         a_size_z;
    logic [SizeWidth-1:0]         b_size_x;
    logic [SizeWidth-1:0]         b_size_y;
    logic [SizeWidth-1:0]         b_size_z;
  } in_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] side;
  } out_t;

endpackage

### design/aabb_overlap_face_classify_unit.sv
// Box overlap test with nearest-face classification, top level.
// Throughput: 1 transaction per cycle while the result is not stalled.
// Six register stages (3 per-axis arithmetic, 3 minimum search) move together;
// a stalled result holds the whole pipeline. Reset clears the valid bits only.
// Depends on aofc_pkg, aofc_axis and aofc_min_sel.
module aabb_overlap_face_classify_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  aofc_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output aofc_pkg::out_t out_data_o
);

  localparam int Depth = 6;
  localparam int GapW  = aofc_pkg::ExtWidth;

  logic [Depth-1:0] valid_d, valid_q;
  logic             en;
  logic [2:0]       axis_hit;
  logic [GapW-1:0]  gap [aofc_pkg::NumGaps];

  // Pipeline advances unless a finished result is held by the receiver
  assign en         = !(valid_q[Depth-1] && out_stall_i);
  assign in_stall_o = !en;
  assign valid_d    = {valid_q[Depth-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= valid_d;
    end
  end

  // Per-axis extents, overlap and gaps
  aofc_axis #(
    .CoordW (aofc_pkg::CoordWidth),
    .SizeW  (aofc_pkg::SizeWidth),
    .ExtW   (GapW)
  ) u_axis_x (
    .clk_i      (clk_i),
    .en_i       (en),
    .a_center_i (in_data_i.a_center_x),
    .b_center_i (in_data_i.b_center_x),
    .a_size_i   (in_data_i.a_size_x),
    .b_size_i   (in_data_i.b_size_x),
    .hit_o      (axis_hit[0]),
    .gap_lo_o   (gap[0]),
    .gap_hi_o   (gap[1])
  );

  aofc_axis #(
    .CoordW (aofc_pkg::CoordWidth),
    .SizeW  (aofc_pkg::SizeWidth),
    .ExtW   (GapW)
  ) u_axis_y (
    .clk_i      (clk_i),
    .en_i       (en),
    .a_center_i (in_data_i.a_center_y),
    .b_center_i (in_data_i.b_center_y),
    .a_size_i   (in_data_i.a_size_y),
    .b_size_i   (in_data_i.b_size_y),
    .hit_o      (axis_hit[1]),
    .gap_lo_o   (gap[2]),
    .gap_hi_o   (gap[3])
  );

  aofc_axis #(
    .CoordW (aofc_pkg::CoordWidth),
    .SizeW  (aofc_pkg::SizeWidth),
    .ExtW   (GapW)
  ) u_axis_z (
    .clk_i      (clk_i),
    .en_i       (en),
    .a_center_i (in_data_i.a_center_z),
    .b_center_i (in_data_i.b_center_z),
    .a_size_i   (in_data_i.a_size_z),
    .b_size_i   (in_data_i.b_size_z),
    .hit_o      (axis_hit[2]),
    .gap_lo_o   (gap[4]),
    .gap_hi_o   (gap[5])
  );

  // Nearest face search and result register
  aofc_min_sel #(
    .GapW (GapW)
  ) u_min_sel (
    .clk_i    (clk_i),
    .en_i     (en),
    .hit_i    (&axis_hit),
    .gap_i    (gap),
    .result_o (out_data_o)
  );

  assign out_valid_o = valid_q[Depth-1];

`ifndef SYNTHESIS
  a_no_hit_side_left : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.hit |-> out_data_o.side == aofc_pkg::SideLeft)
    else $error("side not left on a miss");

  a_side_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.side <= aofc_pkg::SideBehind)
    else $error("side code out of range");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  a_full_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !valid_q[Depth-2] |=> !out_valid_o)
    else $error("result repeated after transaction");
`endif

endmodule

### design/aofc_axis.sv
// One axis of the overlap test: extents, face differences, overlap flag and gaps.
// Three register stages, all advanced by en_i. Depends on aofc_pkg for defaults.
module aofc_axis #(
  parameter int CoordW = aofc_pkg::CoordWidth,
  parameter int SizeW  = aofc_pkg::SizeWidth,
  parameter int ExtW   = ((CoordW > SizeW) ? CoordW : SizeW) + 2
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [CoordW-1:0] a_center_i,
  input  logic signed [CoordW-1:0] b_center_i,
  input  logic [SizeW-1:0]         a_size_i,
  input  logic [SizeW-1:0]         b_size_i,
  output logic                     hit_o,
  output logic [ExtW-1:0]          gap_lo_o,
  output logic [ExtW-1:0]          gap_hi_o
);

  localparam int DiffW = ExtW + 1;

  logic signed [ExtW-1:0] ac_ext, bc_ext, as_ext, bs_ext;
  logic signed [ExtW-1:0] alo_d, ahi_d, blo_d, bhi_d;
  logic signed [ExtW-1:0] alo_q, ahi_q, blo_q, bhi_q;
  logic signed [DiffW-1:0] dlo_d, dhi_d, dlo_q, dhi_q;
  logic signed [DiffW-1:0] dlo_neg;
  logic                    hit_d, hit_q;
  logic [ExtW-1:0]         gap_lo_d, gap_hi_d, gap_lo_q, gap_hi_q;

  // Stage 1: extents at doubled scale, 2c -/+ s
  always_comb begin
    ac_ext = ExtW'(a_center_i);
    bc_ext = ExtW'(b_center_i);
    as_ext = $signed(ExtW'(a_size_i));
    bs_ext = $signed(ExtW'(b_size_i));
    alo_d  = (ac_ext <<< 1) - as_ext;
    ahi_d  = (ac_ext <<< 1) + as_ext;
    blo_d  = (bc_ext <<< 1) - bs_ext;
    bhi_d  = (bc_ext <<< 1) + bs_ext;
  end

  // Stage 2: signed differences between facing extents
  assign dlo_d = DiffW'(alo_q) - DiffW'(bhi_q);
  assign dhi_d = DiffW'(ahi_q) - DiffW'(blo_q);

  // Stage 3: overlap needs dlo <= 0 and dhi >= 0; gaps are then -dlo and dhi
  assign dlo_neg  = -dlo_q;
  assign hit_d    = (dlo_q[DiffW-1] || (dlo_q == '0)) && !dhi_q[DiffW-1];
  assign gap_lo_d = dlo_neg[ExtW-1:0];
  assign gap_hi_d = dhi_q[ExtW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      alo_q    <= alo_d;
      ahi_q    <= ahi_d;
      blo_q    <= blo_d;
      bhi_q    <= bhi_d;
      dlo_q    <= dlo_d;
      dhi_q    <= dhi_d;
      hit_q    <= hit_d;
      gap_lo_q <= gap_lo_d;
      gap_hi_q <= gap_hi_d;
    end
  end

  assign hit_o    = hit_q;
  assign gap_lo_o = gap_lo_q;
  assign gap_hi_o = gap_hi_q;

endmodule

### design/aofc_min_sel.sv
// Registered three-level minimum search over the six face gaps; lowest index wins ties.
// Last stage is the result register. Depends on aofc_pkg for face codes and out_t.
module aofc_min_sel #(
  parameter int GapW = aofc_pkg::ExtWidth
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic              hit_i,
  input  logic [GapW-1:0]   gap_i [aofc_pkg::NumGaps],
  output aofc_pkg::out_t    result_o
);

  logic [GapW-1:0] m4_d [3];
  logic [GapW-1:0] m4_q [3];
  logic [2:0]      i4_d [3];
  logic [2:0]      i4_q [3];
  logic            hit4_q;
  logic [GapW-1:0] m5_d, m5_q, m5c_q;
  logic [2:0]      i5_d, i5_q, i5c_q;
  logic            hit5_q;
  aofc_pkg::out_t  res_d, res_q;
  logic            lt01, lt23, lt45, lt5, lt6;

  // Level 1: pairs within each axis
  always_comb begin
    lt01    = gap_i[1] < gap_i[0];
    lt23    = gap_i[3] < gap_i[2];
    lt45    = gap_i[5] < gap_i[4];
    m4_d[0] = lt01 ? gap_i[1] : gap_i[0];
    i4_d[0] = lt01 ? aofc_pkg::SideRight : aofc_pkg::SideLeft;
    m4_d[1] = lt23 ? gap_i[3] : gap_i[2];
    i4_d[1] = lt23 ? aofc_pkg::SideBottom : aofc_pkg::SideTop;
    m4_d[2] = lt45 ? gap_i[5] : gap_i[4];
    i4_d[2] = lt45 ? aofc_pkg::SideBehind : aofc_pkg::SideFront;
  end

  // Level 2: x winner against y winner
  always_comb begin
    lt5  = m4_q[1] < m4_q[0];
    m5_d = lt5 ? m4_q[1] : m4_q[0];
    i5_d = lt5 ? i4_q[1] : i4_q[0];
  end

  // Level 3: against z winner; no hit reports left
  always_comb begin
    lt6       = m5c_q < m5_q;
    res_d.hit = hit5_q;
    if (hit5_q) begin
      res_d.side = lt6 ? i5c_q : i5_q;
    end else begin
      res_d.side = aofc_pkg::SideLeft;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m4_q   <= m4_d;
      i4_q   <= i4_d;
      hit4_q <= hit_i;
      m5_q   <= m5_d;
      i5_q   <= i5_d;
      m5c_q  <= m4_q[2];
      i5c_q  <= i4_q[2];
      hit5_q <= hit4_q;
      res_q  <= res_d;
    end
  end

  assign result_o = res_q;

endmodule
